@@ hw/rtl/qrs_pkg.sv @@
package qrs_pkg;

	localparam int CoefW = 32;
	localparam int RootW = 48;
	localparam int DiscW = 66;
	localparam int SqrtW = 34;
	localparam int NumW  = 51;   // (-B +/- S) * 2^16, signed
	localparam int DenW  = 34;   // 2*A or 2*B, signed
	localparam int QuoW  = 51;   // quotient magnitude bits kept

	localparam logic [2:0] ST_NONE     = 3'd0;
	localparam logic [2:0] ST_ONE      = 3'd1;
	localparam logic [2:0] ST_TWO      = 3'd2;
	localparam logic [2:0] ST_INFINITE = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	// how an item is routed after the discriminant stage
	typedef struct packed {
		logic [2:0] status;  // final status if no division is needed
		logic       div1;    // root_first comes from a quotient
		logic       div2;    // root_second comes from a quotient
	} qrs_ctl_t;

endpackage

@@ hw/rtl/qrs_div_pipe.sv @@
// Pipelined signed divide, truncating toward zero, one quotient bit per stage.
// Numerator and denominator magnitudes are restored-division iterated over stages.
module qrs_div_pipe #(
	parameter int NW = 51,
	parameter int DW = 34,
	parameter int TW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   vin,
	input  logic signed [NW-1:0]   num,
	input  logic signed [DW-1:0]   den,
	input  logic [TW-1:0]          tag_in,
	output logic                   vout,
	output logic signed [NW:0]     quo,
	output logic [TW-1:0]          tag_out
);
	localparam int NS = NW;

	logic [NW-1:0] rem_s [NS+1];
	logic [NW-1:0] q_s   [NS+1];
	logic [DW-1:0] d_s   [NS+1];
	logic          neg_s [NS+1];
	logic          v_s   [NS+1];
	logic [TW-1:0] t_s   [NS+1];
	logic [NW-1:0] part_s [NS+1];

	always_comb begin
		v_s[0]    = vin;
		t_s[0]    = tag_in;
		neg_s[0]  = num[NW-1] ^ den[DW-1];
		part_s[0] = num[NW-1] ? NW'(-num) : NW'(num);
		d_s[0]    = den[DW-1] ? DW'(-den) : DW'(den);
		rem_s[0]  = '0;
		q_s[0]    = '0;
	end

	for (genvar i = 0; i < NS; i++) begin : g_st
		logic [NW:0] trial;
		logic [NW:0] sub;
		logic        ge;
		assign trial = {rem_s[i], part_s[i][NW-1]};
		assign sub   = trial - (NW+1)'(d_s[i]);
		assign ge    = !sub[NW];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1]  <= ge ? sub[NW-1:0] : trial[NW-1:0];
				q_s[i+1]    <= {q_s[i][NW-2:0], ge};
				part_s[i+1] <= {part_s[i][NW-2:0], 1'b0};
				d_s[i+1]    <= d_s[i];
				neg_s[i+1]  <= neg_s[i];
				t_s[i+1]    <= t_s[i];
			end
		end
	end

	assign vout    = v_s[NS];
	assign tag_out = t_s[NS];
	assign quo     = neg_s[NS] ? -$signed({1'b0, q_s[NS]}) : $signed({1'b0, q_s[NS]});
endmodule

@@ hw/rtl/qrs_sqrt_pipe.sv @@
// Pipelined floor square root of a 66-bit value, one result bit per stage.
module qrs_sqrt_pipe #(
	parameter int TW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           vin,
	input  logic [65:0]    rad,
	input  logic [TW-1:0]  tag_in,
	output logic           vout,
	output logic [33:0]    root,
	output logic [TW-1:0]  tag_out
);
	import qrs_pkg::*;

	// radicand padded to 2*SqrtW bits so each stage takes one bit pair
	logic [DiscW+1:0] x_s [SqrtW+1];
	logic [DiscW-1:0] r_s [SqrtW+1];   // remainder
	logic [SqrtW-1:0] q_s [SqrtW+1];
	logic             v_s [SqrtW+1];
	logic [TW-1:0]    t_s [SqrtW+1];

	assign x_s[0] = {2'b00, rad};
	assign r_s[0] = '0;
	assign q_s[0] = '0;
	assign v_s[0] = vin;
	assign t_s[0] = tag_in;

	for (genvar i = 0; i < SqrtW; i++) begin : g_st
		logic [DiscW+1:0] rem2;
		logic [DiscW+1:0] trial;
		logic [DiscW+1:0] sub;
		logic             ge;
		assign rem2  = {r_s[i], x_s[i][DiscW+1:DiscW]};
		assign trial = {(DiscW+2-SqrtW-2)'(0), q_s[i], 2'b01};
		assign sub   = rem2 - trial;
		assign ge    = rem2 >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				r_s[i+1] <= ge ? sub[DiscW-1:0] : rem2[DiscW-1:0];
				q_s[i+1] <= {q_s[i][SqrtW-2:0], ge};
				x_s[i+1] <= {x_s[i][DiscW-1:0], 2'b00};
				t_s[i+1] <= t_s[i];
			end
		end
	end

	assign vout    = v_s[SqrtW];
	assign root    = q_s[SqrtW];
	assign tag_out = t_s[SqrtW];
endmodule

@@ hw/rtl/quadratic_root_solver_unit.sv @@
// Real roots of a*x^2+b*x+c=0 for signed Q16.16 coefficients, Q32.16 roots with
// status. Fully pipelined: one item per cycle unless the output stalls, through the
// input, product and discriminant registers, one bit-stage per square-root bit,
// numerator stage, one bit-stage per quotient bit and result register. A stall
// on the output freezes the whole pipeline; input stall follows output stall.
module quadratic_root_solver_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [qrs_pkg::CoefW-1:0] coef_a,
	input  logic signed [qrs_pkg::CoefW-1:0] coef_b,
	input  logic signed [qrs_pkg::CoefW-1:0] coef_c,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    root_status,
	output logic signed [qrs_pkg::RootW-1:0] root_first,
	output logic signed [qrs_pkg::RootW-1:0] root_second
);
	import qrs_pkg::*;

	localparam int TagW = 3 + 2 + 1 + 2*CoefW;   // ctl + lin + a + b
	localparam int DTagW = 3 + 2;
	localparam logic signed [NumW:0] QuoMax = {{(NumW-RootW+2){1'b0}}, {(RootW-1){1'b1}}};
	localparam logic signed [NumW:0] QuoMin = {{(NumW-RootW+2){1'b1}}, {(RootW-1){1'b0}}};

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: register inputs
	logic v_s1;
	logic signed [CoefW-1:0] a_s1, b_s1, c_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= coef_a;
			b_s1 <= coef_b;
			c_s1 <= coef_c;
		end
	end

	// stage 2: products
	logic v_s2;
	logic signed [CoefW-1:0] a_s2, b_s2, c_s2;
	logic signed [2*CoefW-1:0] bb_s2, ac_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			c_s2  <= c_s1;
			bb_s2 <= b_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
		end
	end

	// stage 3: discriminant and routing
	logic signed [DiscW-1:0] disc;
	assign disc = DiscW'(bb_s2) - (DiscW'(ac_s2) <<< 2);

	qrs_ctl_t ctl;
	always_comb begin
		ctl = '{status: ST_NONE, div1: 1'b0, div2: 1'b0};
		if (a_s2 == '0) begin
			if (b_s2 == '0) ctl.status = (c_s2 == '0) ? ST_INFINITE : ST_NONE;
			else begin
				ctl.status = ST_ONE;
				ctl.div1   = 1'b1;
			end
		end else if (disc < 0) begin
			ctl.status = ST_NONE;
		end else if (disc == '0) begin
			ctl.status = ST_ONE;
			ctl.div1   = 1'b1;
		end else begin
			ctl.status = ST_TWO;
			ctl.div1   = 1'b1;
			ctl.div2   = 1'b1;
		end
	end

	logic v_s3;
	logic [DiscW-1:0] rad_s3;
	logic [TagW-1:0] tag_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3 <= disc[DiscW-1] ? '0 : disc;
			// for the linear case, carry c as "b" (negated later) and b as "a" divisor
			tag_s3 <= (a_s2 == '0) ? {ctl, 1'b1, b_s2, c_s2} : {ctl, 1'b0, a_s2, b_s2};
		end
	end

	logic sq_v;
	logic [SqrtW-1:0] sq_root;
	logic [TagW-1:0] sq_tag;
	qrs_sqrt_pipe #(.TW(TagW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(v_s3), .rad(rad_s3),
		.tag_in(tag_s3), .vout(sq_v), .root(sq_root), .tag_out(sq_tag)
	);

	// numerator / denominator stage
	qrs_ctl_t sq_ctl;
	logic signed [CoefW-1:0] ta, tb;
	assign sq_ctl = sq_tag[TagW-1 -: 5];
	assign ta     = sq_tag[2*CoefW-1 -: CoefW];
	assign tb     = sq_tag[CoefW-1:0];

	logic lin;
	logic signed [NumW-1:0] nb, ns;
	assign lin = sq_tag[2*CoefW];
	assign nb  = -NumW'(tb);
	assign ns  = NumW'({1'b0, sq_root});

	logic v_s4;
	logic signed [NumW-1:0] n1_s4, n2_s4;
	logic signed [DenW-1:0] d_s4;
	qrs_ctl_t ctl_s4;
	logic lin_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= sq_v;
	end
	// linear items were tagged with b in the a slot; the square root of their radicand
	// is unused for them and the status carries ST_ONE with div1.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= sq_ctl;
			lin_s4 <= lin;
			n1_s4  <= (nb - (sq_ctl.div2 ? ns : '0)) <<< 16;
			n2_s4  <= (nb + ns) <<< 16;
			d_s4   <= DenW'(ta) <<< 1;
		end
	end

	// the linear case reuses the a slot: trunc(-C*2^16/B), pre-doubled below
	// by doubling the numerator too, which leaves the quotient unchanged.
	logic signed [NumW-1:0] n1_adj;
	assign n1_adj = n1_s4 <<< (lin_s4 ? 1 : 0);

	logic dv1, dv2;
	logic signed [NumW:0] q1, q2;
	logic [DTagW-1:0] dt1, dt2;
	qrs_div_pipe #(.NW(NumW), .DW(DenW), .TW(DTagW)) u_div1 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(v_s4), .num(n1_adj), .den(d_s4),
		.tag_in(ctl_s4), .vout(dv1), .quo(q1), .tag_out(dt1)
	);
	qrs_div_pipe #(.NW(NumW), .DW(DenW), .TW(DTagW)) u_div2 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(v_s4), .num(n2_s4), .den(d_s4),
		.tag_in(ctl_s4), .vout(dv2), .quo(q2), .tag_out(dt2)
	);

	qrs_ctl_t fc;
	logic ovf1, ovf2;
	assign fc   = dt1;
	assign ovf1 = fc.div1 && (q1 < QuoMin || q1 > QuoMax);
	assign ovf2 = fc.div2 && (q2 < QuoMin || q2 > QuoMax);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= dv1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ovf1 || ovf2) begin
				root_status <= ST_OVERFLOW;
				root_first  <= '0;
				root_second <= '0;
			end else begin
				root_status <= fc.status;
				root_first  <= fc.div1 ? RootW'(q1) : '0;
				root_second <= fc.div2 ? RootW'(q2) : '0;
			end
		end
	end

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n) dv1 == dv2)
		else $error("divider lanes out of step");
	a_tag_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dv1 |-> dt1 == dt2)
		else $error("divider tags differ");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(root_status) && $stable(root_first))
		else $error("result changed under stall");
	a_two_roots: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_status == ST_NONE |-> root_first == '0 && root_second == '0)
		else $error("unused root not zero");
endmodule

@@ bench/tb_quadratic_root_solver_unit.sv @@
`timescale 1ns / 100ps

module tb_quadratic_root_solver_unit;
	import qrs_pkg::*;

	localparam int LATENCY = 90;
	localparam int N_RANDOM = 1700;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint ROOT_HI = 64'sh00007FFFFFFFFFFF;
	localparam longint ROOT_LO = -ROOT_HI - 1;

	typedef struct {
		logic signed [CoefW-1:0] a;
		logic signed [CoefW-1:0] b;
		logic signed [CoefW-1:0] c;
	} coef_t;

	typedef struct {
		logic [2:0]              status;
		logic signed [RootW-1:0] r1;
		logic signed [RootW-1:0] r2;
	} roots_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CoefW-1:0] coef_a = '0;
	logic signed [CoefW-1:0] coef_b = '0;
	logic signed [CoefW-1:0] coef_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] root_status;
	logic signed [RootW-1:0] root_first;
	logic signed [RootW-1:0] root_second;

	coef_t  pending_coefs[$];
	roots_t expected_roots[$];
	int     errors = 0;
	int     n_sent = 0;
	int     n_checked = 0;
	int     st_count[5] = '{0, 0, 0, 0, 0};
	bit     stim_done = 0;
	bit     hold_rx = 0;
	bit     in_taken = 0;
	longint cycles = 0;
	int     tx_gap = 0;
	int     rx_gap = 0;

	quadratic_root_solver_unit dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [67:0] floor_sqrt(logic [67:0] d);
		logic [67:0] r;
		logic [67:0] t;
		r = '0;
		for (int i = 33; i >= 0; i--) begin
			t = r | (68'd1 << i);
			if (t * t <= d) r = t;
		end
		return r;
	endfunction

	function automatic bit quot_ok(logic signed [127:0] n, logic signed [127:0] d,
			output logic signed [RootW-1:0] q);
		logic signed [127:0] full;
		full = n / d;
		q = full[RootW-1:0];
		return full >= ROOT_LO && full <= ROOT_HI;
	endfunction

	function automatic roots_t solve_roots(coef_t x);
		roots_t res;
		logic signed [127:0] a, b, c, disc, s;
		logic signed [RootW-1:0] q1, q2;
		bit ok1, ok2;
		a = x.a; b = x.b; c = x.c;
		res = '{ST_NONE, '0, '0};
		if (a == 0) begin
			if (b == 0) res.status = (c == 0) ? ST_INFINITE : ST_NONE;
			else if (quot_ok(-c * 65536, b, q1)) res = '{ST_ONE, q1, '0};
			else res.status = ST_OVERFLOW;
		end else begin
			disc = b * b - 4 * a * c;
			if (disc == 0) begin
				if (quot_ok(-b * 65536, 2 * a, q1)) res = '{ST_ONE, q1, '0};
				else res.status = ST_OVERFLOW;
			end else if (disc > 0) begin
				s = floor_sqrt(disc[67:0]);
				ok1 = quot_ok((-b - s) * 65536, 2 * a, q1);
				ok2 = quot_ok((-b + s) * 65536, 2 * a, q2);
				if (ok1 && ok2) res = '{ST_TWO, q1, q2};
				else res.status = ST_OVERFLOW;
			end
		end
		return res;
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 8) << 16;
			2: return -($urandom_range(0, 8) << 16);
			3: return $signed($urandom_range(0, 2000)) - 1000;
			4: return '0;
			default: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 16);
		endcase
	endfunction

	task automatic add_item(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		coef_t x;
		x.a = a; x.b = b; x.c = c;
		pending_coefs.push_back(x);
	endtask

	initial begin
		int k;
		logic [31:0] r, s1, s2;
		// degenerate: all zero, no equation, linear
		add_item(0, 0, 0);
		add_item(0, 0, 32'h0001_0000);
		add_item(0, 32'h0002_0000, 32'h0006_0000);
		add_item(0, 1, 32'h7FFF_FFFF);
		add_item(0, 32'h8000_0000, 32'h8000_0000);
		add_item(0, 32'hFFFF_FFFF, 32'h8000_0000);
		// negative, zero and positive discriminant
		add_item(32'h0001_0000, 0, 32'h0001_0000);
		add_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
		add_item(32'h0001_0000, 0, 32'hFFFC_0000);
		add_item(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
		add_item(1, 32'h7FFF_FFFF, 0);
		add_item(1, 2, 1);
		add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		add_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		add_item(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF);
		add_item(1, 32'h8000_0000, 32'h7FFF_FFFF);
		add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(32'h0001_0000, 0, 0);
		for (k = 0; k < N_RANDOM; k++) begin
			case ($urandom_range(0, 4))
				0: add_item($urandom, $urandom, $urandom);
				1: begin
					// built from roots so two-root and one-root cases are common
					r = $urandom_range(1, 4) << 16;
					s1 = $signed($urandom_range(0, 16)) - 8;
					s2 = ($urandom_range(0, 1)) ? s1 : $signed($urandom_range(0, 16)) - 8;
					add_item(r, -(r * (s1 + s2)), r * s1 * s2);
				end
				default: add_item(rand_coef(), rand_coef(), rand_coef());
			endcase
		end
		#2 ;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// hold item
			end else if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_coefs.size() > 0) begin
				coef_t x;
				x = pending_coefs.pop_front();
				coef_a <= x.a;
				coef_b <= x.b;
				coef_c <= x.c;
				in_valid <= 1'b1;
				tx_gap <= rand_gap();
			end else begin
				in_valid <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			coef_t x;
			x.a = coef_a; x.b = coef_b; x.c = coef_c;
			expected_roots.push_back(solve_roots(x));
			n_sent++;
		end
	end

	// long receiver hold-off early in the run
	initial begin
		@(posedge arst_n);
		repeat (30) @(posedge clk);
		hold_rx = 1;
		repeat (300) @(posedge clk);
		hold_rx = 0;
	end

	always @(negedge clk) begin
		if (hold_rx) out_stall <= 1'b1;
		else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 9) < 3) rx_gap <= rand_gap();
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			roots_t e;
			if (expected_roots.size() == 0) begin
				$error("unexpected result item: status %0d", root_status);
				errors++;
			end else begin
				e = expected_roots.pop_front();
				n_checked++;
				if (e.status <= ST_OVERFLOW) st_count[e.status]++;
				if (root_status !== e.status) begin
					$error("root_status expected %0d got %0d", e.status, root_status);
					errors++;
				end
				if (root_first !== e.r1) begin
					$error("root_first expected %0d got %0d", e.r1, root_first);
					errors++;
				end
				if (root_second !== e.r2) begin
					$error("root_second expected %0d got %0d", e.r2, root_second);
					errors++;
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (!(stim_done && expected_roots.size() == 0)) begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
		repeat (LATENCY * 2) @(posedge clk);
		if (expected_roots.size() != 0) errors++;
		$display("%0d items in, %0d results checked in %0d cycles", n_sent, n_checked, cycles);
		$display("none %0d, one %0d, two %0d, infinite %0d, overflow %0d",
			st_count[0], st_count[1], st_count[2], st_count[3], st_count[4]);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ quadratic_root_solver_unit.f @@
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_div_pipe.sv
hw/rtl/qrs_sqrt_pipe.sv
hw/rtl/quadratic_root_solver_unit.sv
bench/tb_quadratic_root_solver_unit.sv
